// ----- rtl/core/pwm_divider_wrap_search_top_defines.svh -----
// ----------------------------------------------------------------------------
// pwm_divider_wrap_search_top_defines
// Assertion macros shared by the divider/wrap search RTL.
// ----------------------------------------------------------------------------
`ifndef PWM_DIVIDER_WRAP_SEARCH_TOP_DEFINES_SVH
`define PWM_DIVIDER_WRAP_SEARCH_TOP_DEFINES_SVH

// Same-cycle implication, held off while in reset
`define PDWS_ASSERT_IMP(label, ck, rstn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, held off while in reset
`define PDWS_ASSERT_NXT(label, ck, rstn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/pdws_pkg.sv -----
// ----------------------------------------------------------------------------
// pdws_pkg
// Types and constants for the PWM divider and wrap value search.
// ----------------------------------------------------------------------------
`default_nettype none

package pdws_pkg;

  // Field widths
  localparam int unsigned CLK_W  = 28;
  localparam int unsigned FREQ_W = 28;
  localparam int unsigned DIV_W  = 12;
  localparam int unsigned WRAP_W = 16;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned DVD_W  = 32;   // 16 * clock, working divider width
  localparam int unsigned QUO_W  = 31;   // quotient by 3 or 5 fits in 31 bits

  // Defaults
  localparam logic [CLK_W-1:0] SYS_CLK_RESET = 28'd125000000;
  localparam int unsigned      WRAP_LIMIT_DEF = 65534;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_TOO_HIGH = 2'd1;
  localparam logic [ST_W-1:0] ST_TOO_LOW  = 2'd2;

  // Divider thresholds (8.4 fixed point)
  localparam logic [DVD_W-1:0] MIN_F5  = 32'd80;    // 16 * 5
  localparam logic [DVD_W-1:0] MIN_F3  = 32'd48;    // 16 * 3
  localparam logic [DVD_W-1:0] MIN_F2  = 32'd32;    // 16 * 2
  localparam logic [DVD_W-1:0] DIV_MIN = 32'd16;
  localparam logic [DVD_W-1:0] DIV_MAX = 32'd4096;  // 256 * 16

  // Reciprocals: q5 = (d * R5) >> 34, q3 = (d * R3) >> 33, exact for 32-bit d
  localparam logic [DVD_W-1:0] RECIP5 = 32'hCCCC_CCCD;
  localparam logic [DVD_W-1:0] RECIP3 = 32'hAAAA_AAAB;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MUL5,
    S_CHK5,
    S_MUL3,
    S_CHK3,
    S_FINISH
  } pdws_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/pwm_divider_wrap_search_top.sv -----
// Each item passes a transfer, a restoring division, up to 15 factor steps
// (multiply and check for 5, then for 3 or 2; a factor of 5 skips the check
// for 3), a last failing try, then the finish step; a zero frequency goes straight there.
// One item at a time; the next is taken once the result sits in the output
// register, and a stalled output holds the finish step. Reset (rst_n, synchronous,
// active low) clears control and sets the clock register to 125 MHz.
// ----------------------------------------------------------------------------
// pwm_divider_wrap_search_top
// Computes an 8.4 PWM clock divider and a counter wrap value from a wanted
// frequency, using one serial divider then a shared reciprocal multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pwm_divider_wrap_search_top_defines.svh"

module pwm_divider_wrap_search_top
  import pdws_pkg::*;
#(
  parameter int unsigned WRAP_LIMIT = WRAP_LIMIT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // configuration
  input  wire logic              cfg_we,
  input  wire logic [CLK_W-1:0]  cfg_wdata,
  // input channel
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [FREQ_W-1:0] in_wanted_frequency,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [DIV_W-1:0]       out_clock_divider,
  output logic [WRAP_W-1:0]      out_wrap_value,
  output logic [ST_W-1:0]        out_status
);

  localparam logic [WRAP_W+2:0] LIM_X = (WRAP_W+3)'(WRAP_LIMIT);

  // Registers
  pdws_state_t        state_r, state_nxt;
  logic [CLK_W-1:0]   clk_hz_r;
  logic [FREQ_W-1:0]  freq_r, freq_nxt;
  logic [DVD_W-1:0]   d_r, d_nxt;
  logic [FREQ_W-1:0]  rem_r, rem_nxt;
  logic [WRAP_W-1:0]  w_r, w_nxt;
  logic [QUO_W-1:0]   q_r, q_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [DIV_W-1:0]   out_div_r, out_div_nxt;
  logic [WRAP_W-1:0]  out_wrap_r, out_wrap_nxt;
  logic [ST_W-1:0]    out_st_r, out_st_nxt;

  logic               in_xfer;
  logic               out_free;

  // Division step
  logic [FREQ_W:0]    part;
  logic [FREQ_W:0]    diff;
  logic               ge;

  // Shared multiplier and step checks
  logic [DVD_W-1:0]   mul_k;
  logic [2*DVD_W-1:0] prod;
  logic [DVD_W+1:0]   q_times;
  logic               q_exact;
  logic [WRAP_W+2:0]  w5, w3, w2;
  logic               ok5, ok3, ok2;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  assign out_valid         = out_valid_r;
  assign out_clock_divider = out_div_r;
  assign out_wrap_value    = out_wrap_r;
  assign out_status        = out_st_r;

  // Restoring division: one quotient bit per cycle, shifted into d_r
  assign part = {rem_r, d_r[DVD_W-1]};
  assign ge   = (part >= {1'b0, freq_r});
  assign diff = part - {1'b0, freq_r};

  // Reciprocal multiply, then compare q * factor against the divider
  assign mul_k   = (state_r == S_MUL5) ? RECIP5 : RECIP3;
  assign prod    = {{DVD_W{1'b0}}, d_r} * {{DVD_W{1'b0}}, mul_k};
  assign q_times = (state_r == S_CHK5)
                 ? ({3'b0, q_r} << 2) + {3'b0, q_r}
                 : ({3'b0, q_r} << 1) + {3'b0, q_r};
  assign q_exact = (q_times == {2'b0, d_r});

  assign w5 = ({3'b0, w_r} << 2) + {3'b0, w_r};
  assign w3 = ({3'b0, w_r} << 1) + {3'b0, w_r};
  assign w2 = {3'b0, w_r} << 1;

  assign ok5 = (d_r >= MIN_F5) && q_exact && (w5 <= LIM_X);
  assign ok3 = (d_r >= MIN_F3) && q_exact && (w3 <= LIM_X);
  assign ok2 = (d_r >= MIN_F2) && (w2 <= LIM_X);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = (in_wanted_frequency == '0) ? S_FINISH : S_DIV;
        end
      end
      S_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = S_MUL5;
        end
      end
      S_MUL5:  state_nxt = S_CHK5;
      S_CHK5:  state_nxt = ok5 ? S_MUL5 : S_MUL3;
      S_MUL3:  state_nxt = S_CHK3;
      S_CHK3:  state_nxt = (ok3 || ok2) ? S_MUL5 : S_FINISH;
      S_FINISH: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and result register control
  always_comb begin
    freq_nxt      = freq_r;
    d_nxt         = d_r;
    rem_nxt       = rem_r;
    w_nxt         = w_r;
    q_nxt         = q_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_div_nxt   = out_div_r;
    out_wrap_nxt  = out_wrap_r;
    out_st_nxt    = out_st_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          freq_nxt = in_wanted_frequency;
          rem_nxt  = '0;
          w_nxt    = WRAP_W'(1);
          cnt_nxt  = '1;
          // zero frequency: an effectively infinite divider
          d_nxt    = (in_wanted_frequency == '0) ? '1 : {clk_hz_r, 4'b0};
        end
      end
      S_DIV: begin
        rem_nxt = ge ? diff[FREQ_W-1:0] : part[FREQ_W-1:0];
        d_nxt   = {d_r[DVD_W-2:0], ge};
        cnt_nxt = cnt_r - 5'd1;
      end
      S_MUL5: q_nxt = QUO_W'(prod[2*DVD_W-1:34]);
      S_MUL3: q_nxt = prod[2*DVD_W-1:33];
      S_CHK5: begin
        if (ok5) begin
          d_nxt = {1'b0, q_r};
          w_nxt = w5[WRAP_W-1:0];
        end
      end
      S_CHK3: begin
        if (ok3) begin
          d_nxt = {1'b0, q_r};
          w_nxt = w3[WRAP_W-1:0];
        end else if (ok2) begin
          d_nxt = d_r >> 1;
          w_nxt = w2[WRAP_W-1:0];
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (d_r < DIV_MIN) begin
            out_div_nxt  = '0;
            out_wrap_nxt = '0;
            out_st_nxt   = ST_TOO_HIGH;
          end else if (d_r >= DIV_MAX) begin
            out_div_nxt  = '0;
            out_wrap_nxt = '0;
            out_st_nxt   = ST_TOO_LOW;
          end else begin
            out_div_nxt  = d_r[DIV_W-1:0];
            out_wrap_nxt = w_r;
            out_st_nxt   = ST_OK;
          end
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      clk_hz_r    <= SYS_CLK_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        clk_hz_r <= cfg_wdata;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    freq_r     <= freq_nxt;
    d_r        <= d_nxt;
    rem_r      <= rem_nxt;
    w_r        <= w_nxt;
    q_r        <= q_nxt;
    cnt_r      <= cnt_nxt;
    out_div_r  <= out_div_nxt;
    out_wrap_r <= out_wrap_nxt;
    out_st_r   <= out_st_nxt;
  end

  // Assertions
  `PDWS_ASSERT_IMP(a_fail_zero, clk, rst_n,
    out_valid_r && (out_st_r != ST_OK),
    (out_div_r == '0) && (out_wrap_r == '0), "failed result carries non-zero fields")
  `PDWS_ASSERT_IMP(a_ok_range, clk, rst_n,
    out_valid_r && (out_st_r == ST_OK),
    (out_div_r >= DIV_W'(16)) && (out_wrap_r != '0), "ok result out of range")
  `PDWS_ASSERT_IMP(a_wrap_lim, clk, rst_n,
    (state_r == S_CHK5) || (state_r == S_CHK3),
    {3'b0, w_r} <= LIM_X, "wrap value above its limit")
  `PDWS_ASSERT_NXT(a_start, clk, rst_n, in_xfer,
    (state_r == S_DIV) || (state_r == S_FINISH), "accepted item did not start")

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PWM divider and wrap value search. A directed
// table, then random frequencies under a range of clock settings and flow
// control patterns; every result is compared with its table entry or a local predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top
  import pdws_pkg::*;
();

  // Result of one frequency set-up
  typedef struct packed {
    logic [DIV_W-1:0]  divider;
    logic [WRAP_W-1:0] wrap;
    logic [ST_W-1:0]   status;
  } pwm_setting_t;

  // Directed table rows: either a clock register write or a frequency
  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [CLK_W-1:0]  value;
    bit                typed;
    pwm_setting_t      want;
  } dir_row_t;

  localparam int DIR_N        = 26;
  localparam int RAND_PHASES  = 12;
  localparam int PHASE_ITEMS  = 135;
  localparam int SQUEEZE_ITEMS = 30;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 120;
  localparam logic [FREQ_W-1:0] FREQ_MAX = '1;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CLK_W-1:0]  cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [FREQ_W-1:0] in_wanted_frequency = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [DIV_W-1:0]  out_clock_divider;
  logic [WRAP_W-1:0] out_wrap_value;
  logic [ST_W-1:0]   out_status;

  pwm_setting_t      pending_settings[$];
  logic [CLK_W-1:0]  sys_clk_model = SYS_CLK_RESET;
  int                fail_count = 0;
  int                idle_pct = 0;
  int                stall_pct = 0;
  bit                hold_req = 1'b0;
  int                hold_left = 0;
  dir_row_t          dir_rows [DIR_N];

  pwm_divider_wrap_search_top i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_wanted_frequency (in_wanted_frequency),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_clock_divider   (out_clock_divider),
    .out_wrap_value      (out_wrap_value),
    .out_status          (out_status)
  );

  // Clock
  initial begin
    forever #2 clk = ~clk;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("tb_top: FAIL");
    $finish;
  end

  // Divider/wrap search: move factors 5, 3, 2 from the divider into the wrap
  function automatic pwm_setting_t compute_setting(input logic [CLK_W-1:0] clk_hz,
                                                   input logic [FREQ_W-1:0] freq);
    pwm_setting_t res;
    logic [31:0]  div_acc;
    logic [31:0]  wrap_acc;
    bit           searching;
    res = '0;
    if (freq == '0) begin
      res.status = ST_TOO_LOW;
      return res;
    end
    div_acc   = 32'((64'(clk_hz) << 4) / 64'(freq));
    wrap_acc  = 32'd1;
    searching = 1'b1;
    while (searching) begin
      if (div_acc >= 32'd80 && div_acc % 5 == 0 && wrap_acc * 5 <= WRAP_LIMIT_DEF) begin
        div_acc  = div_acc / 5;
        wrap_acc = wrap_acc * 5;
      end else if (div_acc >= 32'd48 && div_acc % 3 == 0 &&
                   wrap_acc * 3 <= WRAP_LIMIT_DEF) begin
        div_acc  = div_acc / 3;
        wrap_acc = wrap_acc * 3;
      end else if (div_acc >= 32'd32 && wrap_acc * 2 <= WRAP_LIMIT_DEF) begin
        div_acc  = div_acc / 2;
        wrap_acc = wrap_acc * 2;
      end else begin
        searching = 1'b0;
      end
    end
    if (div_acc < 32'd16) begin
      res.status = ST_TOO_HIGH;
    end else if (div_acc >= 32'd4096) begin
      res.status = ST_TOO_LOW;
    end else begin
      res.divider = div_acc[DIV_W-1:0];
      res.wrap    = wrap_acc[WRAP_W-1:0];
      res.status  = ST_OK;
    end
    return res;
  endfunction

  // Random frequency: mostly aimed at a chosen starting divider
  function automatic logic [FREQ_W-1:0] pick_frequency(input logic [CLK_W-1:0] clk_hz);
    int unsigned sel;
    logic [63:0] target;
    logic [63:0] f;
    sel = $urandom_range(99);
    if (sel < 70 && clk_hz != '0) begin
      if (sel < 30) begin
        // rich in factors of 3 and 5
        target = 64'($urandom_range(1, 273) * (($urandom_range(1) != 0) ? 15 : 5));
      end else begin
        target = 64'($urandom_range(16, 4095));
      end
      target = target << $urandom_range(0, 16);
      f = (64'(clk_hz) << 4) / target;
      if (f == 0) f = 1;
      if (f > 64'(FREQ_MAX)) f = 64'(FREQ_MAX);
      return f[FREQ_W-1:0];
    end else if (sel < 92) begin
      return FREQ_W'($urandom);
    end else begin
      case ($urandom_range(3))
        0:       return '0;
        1:       return FREQ_W'(1);
        2:       return FREQ_MAX;
        default: return FREQ_W'($urandom_range(2, 16));
      endcase
    end
  endfunction

  // Random clock register value for a phase
  function automatic logic [CLK_W-1:0] pick_clock();
    case ($urandom_range(4))
      0:       return SYS_CLK_RESET;
      1:       return CLK_W'($urandom);
      2:       return CLK_W'($urandom_range(1, 1000000));
      3:       return '1;
      default: return CLK_W'($urandom_range(10000000, 200000000));
    endcase
  endfunction

  // Offer one frequency and wait for its transfer; queue what it should give
  task automatic send_frequency(input logic [FREQ_W-1:0] freq, input bit typed,
                                input pwm_setting_t want);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_wanted_frequency <= freq;
    do @(posedge clk); while (!in_ready);
    if (typed) pending_settings.push_back(want);
    else pending_settings.push_back(compute_setting(sys_clk_model, freq));
  endtask

  // Drain the block, then write the clock register
  task automatic change_clock(input logic [CLK_W-1:0] hz);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_settings.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= hz;
    @(posedge clk);
    cfg_we        <= 1'b0;
    sys_clk_model = hz;
  endtask

  // Result side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Result checker: each transfer against the oldest expectation
  always @(posedge clk) begin
    pwm_setting_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_settings.size() == 0) begin
        $error("unexpected result: divider %0d wrap %0d status %0d",
               out_clock_divider, out_wrap_value, out_status);
        fail_count++;
      end else begin
        want = pending_settings.pop_front();
        if (out_clock_divider !== want.divider) begin
          $error("clock_divider: expected %0d, got %0d", want.divider, out_clock_divider);
          fail_count++;
        end
        if (out_wrap_value !== want.wrap) begin
          $error("wrap_value: expected %0d, got %0d", want.wrap, out_wrap_value);
          fail_count++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          fail_count++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    int mode;
    dir_rows = '{
      // reset clock of 125 MHz
      '{ROW_ITEM, 28'd0,         1'b1, '{12'd0,  16'd0, ST_TOO_LOW}},
      '{ROW_ITEM, 28'd125000000, 1'b1, '{12'd16, 16'd1, ST_OK}},
      '{ROW_ITEM, 28'hFFFFFFF,   1'b1, '{12'd0,  16'd0, ST_TOO_HIGH}},
      '{ROW_ITEM, 28'd1,         1'b0, '{12'd0,  16'd0, ST_OK}},
      '{ROW_ITEM, 28'd62500000,  1'b0, '{12'd0,  16'd0, ST_OK}},
      '{ROW_ITEM, 28'd1000,      1'b0, '{12'd0,  16'd0, ST_OK}},
      '{ROW_ITEM, 28'd20000,     1'b0, '{12'd0,  16'd0, ST_OK}},
      '{ROW_ITEM, 28'hAAAAAAA,   1'b0, '{12'd0,  16'd0, ST_OK}},
      '{ROW_ITEM, 28'h5555555,   1'b0, '{12'd0,  16'd0, ST_OK}},
      '{ROW_ITEM, 28'd488,       1'b0, '{12'd0,  16'd0, ST_OK}},
      // largest clock: widest starting divider
      '{ROW_CFG,  28'hFFFFFFF,   1'b0, '{12'd0,  16'd0, ST_OK}},
      '{ROW_ITEM, 28'd1,         1'b0, '{12'd0,  16'd0, ST_OK}},
      '{ROW_ITEM, 28'hFFFFFFF,   1'b1, '{12'd16, 16'd1, ST_OK}},
      '{ROW_ITEM, 28'd3,         1'b0, '{12'd0,  16'd0, ST_OK}},
      // smallest non-zero clock
      '{ROW_CFG,  28'd1,         1'b0, '{12'd0,  16'd0, ST_OK}},
      '{ROW_ITEM, 28'd1,         1'b1, '{12'd16, 16'd1, ST_OK}},
      '{ROW_ITEM, 28'd2,         1'b1, '{12'd0,  16'd0, ST_TOO_HIGH}},
      '{ROW_ITEM, 28'd0,         1'b1, '{12'd0,  16'd0, ST_TOO_LOW}},
      // clock of zero: always too high, unless the frequency is zero too
      '{ROW_CFG,  28'd0,         1'b0, '{12'd0,  16'd0, ST_OK}},
      '{ROW_ITEM, 28'd12345,     1'b1, '{12'd0,  16'd0, ST_TOO_HIGH}},
      '{ROW_ITEM, 28'd0,         1'b1, '{12'd0,  16'd0, ST_TOO_LOW}},
      '{ROW_ITEM, 28'hFFFFFFF,   1'b1, '{12'd0,  16'd0, ST_TOO_HIGH}},
      // 48 MHz, including a long factor search
      '{ROW_CFG,  28'd48000000,  1'b0, '{12'd0,  16'd0, ST_OK}},
      '{ROW_ITEM, 28'd48000,     1'b0, '{12'd0,  16'd0, ST_OK}},
      '{ROW_ITEM, 28'd3000000,   1'b0, '{12'd0,  16'd0, ST_OK}},
      '{ROW_ITEM, 28'd732,       1'b0, '{12'd0,  16'd0, ST_OK}}
    };

    // reset
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, no idling
    for (int i = 0; i < DIR_N; i++) begin
      if (dir_rows[i].kind == ROW_CFG) change_clock(dir_rows[i].value);
      else send_frequency(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);
    end

    // back-pressure: output held off while frequencies keep coming
    change_clock(SYS_CLK_RESET);
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 1'b1;
    for (int i = 0; i < SQUEEZE_ITEMS; i++) begin
      send_frequency(pick_frequency(sys_clk_model), 1'b0, '0);
    end

    // random phases, each with its own clock and flow control pattern
    for (int p = 0; p < RAND_PHASES; p++) begin
      change_clock(pick_clock());
      mode = p % 4;
      case (mode)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 78; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 78; end
        default: begin idle_pct = 28; stall_pct = 28; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_frequency(pick_frequency(sys_clk_model), 1'b0, '0);
      end
    end

    // drain and let the block settle
    in_valid <= 1'b0;
    while (pending_settings.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_settings.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
